>>> hw/rtl/pid_controller_clamped_integral_defines.svh
// Assertion macros shared by the checker of the clamped-integral PID controller.
// No dependencies; the checker file includes this header.
`ifndef PID_CONTROLLER_CLAMPED_INTEGRAL_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_INTEGRAL_DEFINES_SVH

// Generic clocked assertion with an active-low reset that disables it.
`define PIDC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Shorthand on the block's own clock and reset.
`define PIDC_ASSERT(lbl, prop, msg) \
  `PIDC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> hw/rtl/pidc_pkg.sv
// Shared types, constants and saturation helper of the clamped-integral PID controller.
// No dependencies; the top level, multiplier, divider and sequencer import it.
`default_nettype none

package pidc_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned GainW   = 24;
  localparam int unsigned DtW     = 24;
  localparam int unsigned LimitW  = 31;
  localparam int unsigned IsumW   = 48;
  localparam int unsigned MulAW   = 32;
  localparam int unsigned MulBW   = 25;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned SatInW  = ProdW - 16;
  localparam int unsigned DivW    = 56;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [GainW-1:0]  KpReset    = 24'd78643;
  localparam logic [GainW-1:0]  KiReset    = 24'd655;
  localparam logic [GainW-1:0]  KdReset    = 24'd3277;
  localparam logic [DtW-1:0]    DtReset    = 24'd16777;
  localparam logic [LimitW-1:0] LimitReset = 31'd6553600;

  localparam logic signed [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    CfgKp    = 3'd0,
    CfgKi    = 3'd1,
    CfgKd    = 3'd2,
    CfgDt    = 3'd3,
    CfgLimit = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    StIdle,
    StP,
    StInc,
    StAcc,
    StClamp,
    StI,
    StIres,
    StDwait,
    StD,
    StDres,
    StSum
  } state_e;

  typedef enum logic [1:0] {
    MulKpErr,
    MulErrDt,
    MulKiInt,
    MulKdDer
  } mul_op_e;

  typedef struct packed {
    logic    in_ready;
    mul_op_e mul_op;
    logic    ld_err;
    logic    ld_p;
    logic    ld_acc;
    logic    ld_clamp;
    logic    ld_i;
    logic    ld_deriv;
    logic    ld_d;
    logic    ld_out;
    logic    div_start;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic div_busy;
    logic out_free;
  } seq_stat_t;

  typedef struct packed {
    logic                    sat;
    logic signed [DataW-1:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [SatInW-1:0] x);
    sat_t r;
    r.sat = 1'b0;
    r.val = x[DataW-1:0];
    if (x[SatInW-1:DataW-1] != {(SatInW-DataW+1){x[SatInW-1]}}) begin
      r.sat = 1'b1;
      r.val = x[SatInW-1] ? SatMin : SatMax;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pid_controller_clamped_integral.sv
// Top level of the clamped-integral PID controller: registers, datapath, output stage.
// Depends on pidc_pkg, pidc_mul, pidc_div and pidc_seq.
//
//   Channel  Direction  Handshake                Payload
//   in       request    in_valid_i / in_stall_o  target_value_i, measured_value_i
//   out      result     out_valid_o / out_stall_i drive_value_o, saturated_flag_o
//   cfg      write      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A new request is accepted only after the result of the last one is loaded; the
// sequencer steps through its states in between. The 56-step serial divider for the
// derivative paces each request; the four products share one multiplier.
// Reset is asynchronous and active low and loads the default gains, period and limit.
// A stalled result holds in the output register while the next request is accepted.
`default_nettype none

module pid_controller_clamped_integral (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [pidc_pkg::DataW-1:0]   target_value_i,
  input  logic signed [pidc_pkg::DataW-1:0]   measured_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pidc_pkg::DataW-1:0]   drive_value_o,
  output logic                                saturated_flag_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pidc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [pidc_pkg::LimitW-1:0]         cfg_data_i
);
  import pidc_pkg::*;

  logic [GainW-1:0]  kp_q, ki_q, kd_q;
  logic [DtW-1:0]    dt_q;
  logic [LimitW-1:0] limit_q;

  logic signed [IsumW-1:0] isum_q;
  logic signed [DataW-1:0] prev_q;

  logic signed [DataW-1:0] err_q, p_q, i_q, d_q, deriv_q;
  logic signed [IsumW:0]   acc_q;
  logic                    flag_q;

  logic                    out_valid_q;
  logic signed [DataW-1:0] drive_q;
  logic                    out_flag_q;

  ctrl_t     ctrl;
  seq_stat_t stat;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;

  logic                    div_busy;
  logic [DivW-1:0]         quot;
  logic [DivW-1:0]         dividend;

  logic signed [DataW:0]   diff_in;
  logic signed [DataW:0]   diff_err;
  logic [DataW:0]          diff_abs;
  sat_t                    err_s, p_s, i_s, d_s, drive_s;
  logic signed [IsumW:0]   acc_d;
  logic signed [IsumW:0]   lim;
  logic signed [IsumW:0]   lim_neg;
  logic signed [IsumW:0]   clamp_val;
  logic signed [DataW-1:0] deriv_val;
  logic                    deriv_flag;
  logic signed [DataW+1:0] sum;
  logic                    out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= KpReset;
      ki_q    <= KiReset;
      kd_q    <= KdReset;
      dt_q    <= DtReset;
      limit_q <= LimitReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgKp:    kp_q    <= cfg_data_i[GainW-1:0];
        CfgKi:    ki_q    <= cfg_data_i[GainW-1:0];
        CfgKd:    kd_q    <= cfg_data_i[GainW-1:0];
        CfgDt:    dt_q    <= cfg_data_i[DtW-1:0];
        CfgLimit: limit_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  assign out_free      = !out_valid_q || !out_stall_i;
  assign stat.in_valid = in_valid_i;
  assign stat.div_busy = div_busy;
  assign stat.out_free = out_free;
  assign in_stall_o    = !ctrl.in_ready;

  pidc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  always_comb begin
    unique case (ctrl.mul_op)
      MulKpErr: begin
        mul_a = err_q;
        mul_b = $signed({kp_q[GainW-1], kp_q});
      end
      MulErrDt: begin
        mul_a = err_q;
        mul_b = $signed({1'b0, dt_q});
      end
      MulKiInt: begin
        mul_a = isum_q[IsumW-1:16];
        mul_b = $signed({ki_q[GainW-1], ki_q});
      end
      MulKdDer: begin
        mul_a = deriv_q;
        mul_b = $signed({kd_q[GainW-1], kd_q});
      end
      default: begin
        mul_a = err_q;
        mul_b = '0;
      end
    endcase
  end

  pidc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign diff_err = $signed({err_q[DataW-1], err_q}) - $signed({prev_q[DataW-1], prev_q});
  assign diff_abs = diff_err[DataW] ? 33'(-diff_err) : diff_err;
  assign dividend = {diff_abs[DataW-1:0], {DtW{1'b0}}};

  pidc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.div_start),
    .dividend_i (dividend),
    .divisor_i  (dt_q),
    .busy_o     (div_busy),
    .quotient_o (quot)
  );

  assign diff_in = $signed({target_value_i[DataW-1], target_value_i})
                 - $signed({measured_value_i[DataW-1], measured_value_i});
  assign err_s = sat32($signed({{(SatInW-DataW-1){diff_in[DataW]}}, diff_in}));
  assign p_s   = sat32(prod[ProdW-1:16]);
  assign i_s   = sat32(prod[ProdW-1:16]);
  assign d_s   = sat32(prod[ProdW-1:16]);

  assign acc_d   = $signed({isum_q[IsumW-1], isum_q}) + $signed({prod[55], prod[55:8]});
  assign lim     = $signed({2'b00, limit_q, 16'b0});
  assign lim_neg = -lim;

  always_comb begin
    if (acc_q > lim) begin
      clamp_val = lim;
    end else if (acc_q < lim_neg) begin
      clamp_val = lim_neg;
    end else begin
      clamp_val = acc_q;
    end
  end

  always_comb begin
    deriv_flag = 1'b0;
    deriv_val  = quot[DataW-1:0];
    if (dt_q == '0) begin
      deriv_flag = 1'b1;
      deriv_val  = '0;
    end else if (!diff_err[DataW]) begin
      if (quot[DivW-1:DataW-1] != '0) begin
        deriv_flag = 1'b1;
        deriv_val  = SatMax;
      end
    end else begin
      if (quot[DivW-1:DataW] != '0 || (quot[DataW-1] && quot[DataW-2:0] != '0)) begin
        deriv_flag = 1'b1;
        deriv_val  = SatMin;
      end else begin
        deriv_val = -$signed(quot[DataW-1:0]);
      end
    end
  end

  assign sum = $signed({{2{p_q[DataW-1]}}, p_q}) + $signed({{2{i_q[DataW-1]}}, i_q})
             + $signed({{2{d_q[DataW-1]}}, d_q});
  assign drive_s = sat32($signed({{(SatInW-DataW-2){sum[DataW+1]}}, sum}));

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_err) begin
      err_q  <= err_s.val;
      flag_q <= err_s.sat;
    end else begin
      if (ctrl.ld_p) begin
        p_q    <= p_s.val;
        flag_q <= flag_q | p_s.sat;
      end
      if (ctrl.ld_i) begin
        i_q    <= i_s.val;
        flag_q <= flag_q | i_s.sat;
      end
      if (ctrl.ld_deriv) begin
        deriv_q <= deriv_val;
        flag_q  <= flag_q | deriv_flag;
      end
      if (ctrl.ld_d) begin
        d_q    <= d_s.val;
        flag_q <= flag_q | d_s.sat;
      end
    end
    if (ctrl.ld_acc) begin
      acc_q <= acc_d;
    end
    if (ctrl.ld_out) begin
      drive_q    <= drive_s.val;
      out_flag_q <= flag_q | drive_s.sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isum_q      <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl.ld_clamp) begin
        isum_q <= clamp_val[IsumW-1:0];
      end
      if (ctrl.ld_out) begin
        prev_q      <= err_q;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_value_o    = drive_q;
  assign saturated_flag_o = out_flag_q;

endmodule

`default_nettype wire

>>> hw/rtl/pidc_mul.sv
// Shared signed multiplier with a registered product.
// Depends on pidc_pkg for the operand widths.
`default_nettype none

module pidc_mul (
  input  logic                              clk_i,
  input  logic signed [pidc_pkg::MulAW-1:0] a_i,
  input  logic signed [pidc_pkg::MulBW-1:0] b_i,
  output logic signed [pidc_pkg::ProdW-1:0] prod_o
);
  import pidc_pkg::*;

  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

>>> hw/rtl/pidc_div.sv
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on pidc_pkg for the operand widths.
`default_nettype none

module pidc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [pidc_pkg::DivW-1:0]      dividend_i,
  input  logic [pidc_pkg::DtW-1:0]       divisor_i,
  output logic                           busy_o,
  output logic [pidc_pkg::DivW-1:0]      quotient_o
);
  import pidc_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] dq_q, dq_d;
  logic [DtW-1:0]  rem_q, rem_d;
  logic [DtW:0]    trial;
  logic [DtW:0]    diff;

  assign trial = {rem_q, dq_q[DivW-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivW);
      dq_d   = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = diff[DtW-1:0];
        dq_d  = {dq_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = trial[DtW-1:0];
        dq_d  = {dq_q[DivW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = dq_q;

endmodule

`default_nettype wire

>>> hw/rtl/pidc_seq.sv
// Sequencer that steps the shared multiplier and the divider through one sample.
// Depends on pidc_pkg for the state, control and status types.
`default_nettype none

module pidc_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pidc_pkg::seq_stat_t  stat_i,
  output pidc_pkg::ctrl_t      ctrl_o
);
  import pidc_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (stat_i.in_valid) state_d = StP;
      StP:     state_d = StInc;
      StInc:   state_d = StAcc;
      StAcc:   state_d = StClamp;
      StClamp: state_d = StI;
      StI:     state_d = StIres;
      StIres:  state_d = StDwait;
      StDwait: if (!stat_i.div_busy) state_d = StD;
      StD:     state_d = StDres;
      StDres:  state_d = StSum;
      StSum:   if (stat_i.out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ctrl_o        = '0;
    ctrl_o.mul_op = MulKpErr;
    unique case (state_q)
      StIdle: begin
        ctrl_o.in_ready = 1'b1;
        ctrl_o.ld_err   = stat_i.in_valid;
      end
      StP: begin
        ctrl_o.mul_op    = MulKpErr;
        ctrl_o.div_start = 1'b1;
      end
      StInc: begin
        ctrl_o.mul_op = MulErrDt;
        ctrl_o.ld_p   = 1'b1;
      end
      StAcc:   ctrl_o.ld_acc = 1'b1;
      StClamp: ctrl_o.ld_clamp = 1'b1;
      StI:     ctrl_o.mul_op = MulKiInt;
      StIres:  ctrl_o.ld_i = 1'b1;
      StDwait: ctrl_o.ld_deriv = !stat_i.div_busy;
      StD:     ctrl_o.mul_op = MulKdDer;
      StDres:  ctrl_o.ld_d = 1'b1;
      StSum:   ctrl_o.ld_out = stat_i.out_free;
      default: ctrl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pidc_checker.sv
// Port-level checker for the clamped-integral PID controller, bound to the top level.
// Depends on pid_controller_clamped_integral_defines.svh for the assertion macros.
`default_nettype none
`include "pid_controller_clamped_integral_defines.svh"

module pidc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] drive_value_o,
  input logic        saturated_flag_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  `PIDC_ASSERT(a_out_hold,
               out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_value_o)
                 && $stable(saturated_flag_o),
               "Stalled result changed")
  `PIDC_ASSERT(a_busy_after_req,
               in_valid_i && !in_stall_o |=> in_stall_o,
               "Block took a request while busy")
  `PIDC_ASSERT(a_result_frees_input,
               $rose(out_valid_o) |-> !in_stall_o,
               "Result loaded but input still stalled")
  `PIDC_ASSERT(a_cfg_always_ready,
               cfg_valid_i |-> cfg_ready_o,
               "Configuration write refused")

endmodule

bind pid_controller_clamped_integral pidc_checker u_pidc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .drive_value_o    (drive_value_o),
  .saturated_flag_o (saturated_flag_o),
  .cfg_valid_i      (cfg_valid_i),
  .cfg_ready_o      (cfg_ready_o)
);

`default_nettype wire

>>> verif/tb_top.sv
// Testbench of the clamped-integral PID controller: directed and random requests,
// register writes between phases, and a bit-exact predictor checked on every result.
// Depends on pidc_pkg and pid_controller_clamped_integral.
module tb_top;
  import pidc_pkg::*;

  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned DrainCycles  = 64;
  localparam int unsigned HoldCycles   = 600;
  localparam longint      Max32        = 64'sd2147483647;
  localparam longint      Min32        = -64'sd2147483648;

  typedef struct {
    logic signed [DataW-1:0] drive;
    logic                    flag;
  } drive_t;

  logic                    clk_i            = 1'b0;
  logic                    rst_ni           = 1'b0;
  logic                    in_valid_i       = 1'b0;
  logic                    in_stall_o;
  logic signed [DataW-1:0] target_value_i   = '0;
  logic signed [DataW-1:0] measured_value_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i      = 1'b0;
  logic signed [DataW-1:0] drive_value_o;
  logic                    saturated_flag_o;
  logic                    cfg_valid_i      = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxW-1:0]      cfg_index_i      = '0;
  logic [LimitW-1:0]       cfg_data_i       = '0;

  longint      gain_p, gain_i, gain_d, period, limit;
  longint      integ_acc, last_error;
  logic        sat_seen;
  drive_t      drive_q[$];
  int unsigned fail_count = 0;
  int unsigned cycles     = 0;
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  bit          hold_req   = 1'b0;

  pid_controller_clamped_integral dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .target_value_i   (target_value_i),
    .measured_value_i (measured_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .drive_value_o    (drive_value_o),
    .saturated_flag_o (saturated_flag_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic longint clip32(input longint x);
    if (x > Max32) begin
      sat_seen = 1'b1;
      return Max32;
    end
    if (x < Min32) begin
      sat_seen = 1'b1;
      return Min32;
    end
    return x;
  endfunction

  function automatic drive_t pid_predict(input logic signed [DataW-1:0] target,
                                         input logic signed [DataW-1:0] measured);
    drive_t r;
    longint err, p_term, i_term, d_term, deriv, lim, sum;
    sat_seen = 1'b0;
    err = clip32(longint'(target) - longint'(measured));
    p_term = clip32((gain_p * err) >>> 16);
    integ_acc = integ_acc + ((err * period) >>> 8);
    lim = limit * 65536;
    if (integ_acc > lim) integ_acc = lim;
    if (integ_acc < -lim) integ_acc = -lim;
    i_term = clip32((gain_i * (integ_acc >>> 16)) >>> 16);
    if (period == 0) begin
      deriv = 0;
      sat_seen = 1'b1;
    end else begin
      deriv = clip32(((err - last_error) * 64'sd16777216) / period);
    end
    d_term = clip32((gain_d * deriv) >>> 16);
    last_error = err;
    sum = clip32(p_term + i_term + d_term);
    r.drive = sum[DataW-1:0];
    r.flag = sat_seen;
    return r;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [LimitW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgKp:    gain_p = longint'($signed(data[GainW-1:0]));
      CfgKi:    gain_i = longint'($signed(data[GainW-1:0]));
      CfgKd:    gain_d = longint'($signed(data[GainW-1:0]));
      CfgDt:    period = longint'(data[DtW-1:0]);
      CfgLimit: limit = longint'(data);
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic signed [DataW-1:0] target,
                             input logic signed [DataW-1:0] measured);
    int unsigned gap;
    in_valid_i <= 1'b1;
    target_value_i <= target;
    measured_value_i <= measured;
    do @(posedge clk_i); while (in_stall_o);
    drive_q.push_back(pid_predict(target, measured));
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random(input logic signed [DataW-1:0] setpoint);
    logic signed [DataW-1:0] t, m;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        t = $urandom;
        m = $urandom;
      end
      3: begin
        t = setpoint;
        m = $urandom;
      end
      default: begin
        t = setpoint;
        m = setpoint + (int'($urandom_range(0, 1 << 18)) - (1 << 17));
      end
    endcase
    send_sample(t, m);
  endtask

  task automatic settle();
    if (in_valid_i) in_valid_i <= 1'b0;
    do @(posedge clk_i); while (drive_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [LimitW-1:0] pick_gain();
    logic [LimitW-1:0] d;
    d = LimitW'($urandom);
    case ($urandom_range(0, 7))
      0: d[GainW-1:0] = 24'h7FFFFF;
      1: d[GainW-1:0] = 24'h800000;
      2: d[GainW-1:0] = '0;
      default: d[GainW-1:0] = GainW'($urandom_range(0, 1 << 19)) - GainW'(1 << 18);
    endcase
    return d;
  endfunction

  always @(posedge clk_i) begin
    drive_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (drive_q.size() == 0) begin
        $display("%0t unexpected result: drive %0d flag %0b", $time, drive_value_o,
                 saturated_flag_o);
        fail_count++;
      end else begin
        want = drive_q.pop_front();
        if (drive_value_o !== want.drive) begin
          $display("%0t drive_value mismatch: expected %0d actual %0d", $time, want.drive,
                   drive_value_o);
          fail_count++;
        end
        if (saturated_flag_o !== want.flag) begin
          $display("%0t saturated_flag mismatch: expected %0b actual %0b", $time, want.flag,
                   saturated_flag_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : stall_driver
    int unsigned burst;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 19);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic test_reset_defaults();
    send_sample(32'sd0, 32'sd0);
    send_sample(32'sd327680, 32'sd0);
    send_sample(32'sd0, 32'sd196608);
  endtask

  task automatic test_input_extremes();
    send_sample(32'sh7FFFFFFF, 32'sh80000000);
    send_sample(32'sh80000000, 32'sh7FFFFFFF);
    send_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_sample(32'sh80000000, 32'sh80000000);
    send_sample(32'sh80000000, 32'sd0);
  endtask

  task automatic test_gain_extremes();
    settle();
    write_reg(CfgKp, 31'h007FFFFF);
    write_reg(CfgKi, 31'h7F800000);
    write_reg(CfgKd, 31'h007FFFFF);
    write_reg(CfgDt, 31'd1);
    write_reg(CfgLimit, 31'h7FFFFFFF);
    cfg_valid_i <= 1'b0;
    send_sample(32'sh7FFFFFFF, 32'sd0);
    send_sample(32'sd1, 32'sd0);
    send_sample(32'sh80000000, 32'sh7FFFFFFF);
    settle();
    write_reg(CfgKp, 31'h00800000);
    write_reg(CfgKi, 31'h007FFFFF);
    write_reg(CfgKd, 31'h00800000);
    write_reg(CfgDt, 31'h00FFFFFF);
    write_reg(CfgLimit, 31'd0);
    cfg_valid_i <= 1'b0;
    send_sample(32'sh7FFFFFFF, 32'sh80000000);
    send_sample(-32'sd1, 32'sd1);
  endtask

  task automatic test_zero_period();
    settle();
    write_reg(CfgKp, LimitW'(KpReset));
    write_reg(CfgKi, LimitW'(KiReset));
    write_reg(CfgKd, LimitW'(KdReset));
    write_reg(CfgDt, 31'd0);
    write_reg(CfgLimit, LimitW'(LimitReset));
    cfg_valid_i <= 1'b0;
    send_sample(32'sd65536, 32'sd0);
    send_sample(32'sd0, 32'sd65536);
    send_sample(32'sd0, 32'sd0);
  endtask

  task automatic test_limit_lowered();
    settle();
    write_reg(CfgKi, 31'd65536);
    write_reg(CfgDt, 31'h00FFFFFF);
    write_reg(CfgLimit, 31'h7FFFFFFF);
    cfg_valid_i <= 1'b0;
    send_sample(32'sh40000000, 32'sd0);
    send_sample(32'sh40000000, 32'sd0);
    settle();
    write_reg(CfgLimit, 31'd65536);
    cfg_valid_i <= 1'b0;
    send_sample(32'sd0, 32'sd0);
    send_sample(32'sd0, 32'sh40000000);
  endtask

  task automatic test_unknown_index();
    settle();
    for (int k = int'(CfgLimit) + 1; k < (1 << CfgIdxW); k++) begin
      write_reg(CfgIdxW'(k), LimitW'($urandom));
    end
    cfg_valid_i <= 1'b0;
    send_sample(32'sd131072, 32'sd65536);
    send_sample(32'sd65536, 32'sd131072);
  endtask

  task automatic test_random_phases(input int unsigned phases, input int unsigned items,
                                    input bit idle);
    logic signed [DataW-1:0] setpoint;
    logic [LimitW-1:0]       d;
    for (int unsigned ph = 0; ph < phases; ph++) begin
      settle();
      write_reg(CfgKp, pick_gain());
      write_reg(CfgKi, pick_gain());
      write_reg(CfgKd, pick_gain());
      d = LimitW'($urandom);
      case ($urandom_range(0, 9))
        0: d[DtW-1:0] = '0;
        1: d[DtW-1:0] = 24'hFFFFFF;
        2: d[DtW-1:0] = 24'd1;
        3: ;
        default: d[DtW-1:0] = DtW'($urandom_range(1000, 100000));
      endcase
      write_reg(CfgDt, d);
      case ($urandom_range(0, 7))
        0: d = '0;
        1: d = 31'h7FFFFFFF;
        2: d = LimitW'($urandom);
        default: d = LimitW'($urandom_range(65536, 1 << 26));
      endcase
      write_reg(CfgLimit, d);
      cfg_valid_i <= 1'b0;
      tx_idle_en = idle && ($urandom_range(0, 3) != 0);
      rx_idle_en = idle && ($urandom_range(0, 3) != 0);
      setpoint = DataW'($urandom_range(0, 1 << 24)) - DataW'(1 << 23);
      repeat (items) send_random(setpoint);
    end
  endtask

  task automatic test_output_hold();
    tx_idle_en = 1'b0;
    hold_req = 1'b1;
    repeat (12) send_random(DataW'($urandom));
  endtask

  initial begin
    gain_p = longint'($signed(KpReset));
    gain_i = longint'($signed(KiReset));
    gain_d = longint'($signed(KdReset));
    period = longint'(DtReset);
    limit = longint'(LimitReset);
    integ_acc = 0;
    last_error = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_reset_defaults();
    test_input_extremes();
    test_gain_extremes();
    test_zero_period();
    test_limit_lowered();
    test_unknown_index();
    test_random_phases(10, 160, 1'b1);
    test_output_hold();
    test_random_phases(1, 180, 1'b0);
    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/pidc_pkg.sv
hw/rtl/pidc_mul.sv
hw/rtl/pidc_div.sv
hw/rtl/pidc_seq.sv
hw/rtl/pid_controller_clamped_integral.sv
hw/rtl/pidc_checker.sv
verif/tb_top.sv
